[src/fbt_pkg.sv]
// ----------------------------------------------------------------------------
// fbt_pkg: shared types and constants of the threshold binarizer
// Sizes of the pixel window, coefficient and sum widths, register indexes and
// the word that travels along the multiply-accumulate cell chain.
// ----------------------------------------------------------------------------
package fbt_pkg;

    // filter geometry
    localparam int TAPS       = 9;
    localparam int PIXEL_BITS = 8;
    localparam int COEFF_BITS = 16;

    // configuration register layout
    localparam int SLOT_BITS  = 16;
    localparam int PER_REG    = 3;
    localparam int COEFF_REGS = 3;
    localparam int CFG_W      = PER_REG * SLOT_BITS;
    localparam int LEVEL_W    = 32;
    localparam int CFG_IDX_W  = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_TAPS_0_2 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_TAPS_3_5 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_TAPS_6_8 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_DECISION_LEVEL = CFG_IDX_W'(3);

    // arithmetic widths
    localparam int PROD_W = PIXEL_BITS + 1 + COEFF_BITS;
    localparam int ACC_W  = PROD_W + $clog2(TAPS);
    localparam int CMP_W  = (ACC_W > LEVEL_W) ? ACC_W : LEVEL_W;
    localparam int FILL_W = $clog2(TAPS + 1);

    typedef logic [PIXEL_BITS-1:0]         t_pix;
    typedef logic signed [COEFF_BITS-1:0]  t_coeff;
    typedef logic signed [LEVEL_W-1:0]     t_level;
    typedef logic [TAPS-1:0][PIXEL_BITS-1:0] t_win;

    // word handed from cell to cell: remaining pixels and the running sum
    typedef struct packed {
        logic                    vld;
        logic                    full;
        logic signed [ACC_W-1:0] psum;
        t_win                    pix;
    } t_mac_word;

endpackage

[src/fir_threshold_binarizer.sv]
// ----------------------------------------------------------------------------
// fir_threshold_binarizer: 9-tap FIR filter with threshold decision
//
// Pixels arrive on the input channel (i_in_valid, o_in_stall, i_pixel), one
// word per cycle at most. Each accepted pixel shifts into the window and the
// window is sent down a chain of TAPS multiply-accumulate cells, one tap per
// cell, followed by the compare and output register. Results leave on the
// output channel (o_out_valid, i_out_stall, o_decision, o_valid_res), one per
// accepted pixel, in order.
// Each accepted window is registered in every cell in turn and then in the
// output register; the chain takes one pixel per cycle while the output is
// not stalled, each cell doing its multiply-add in front of its register.
// A stall on the output holds the result word; stages behind it keep filling
// their empty slots, and o_in_stall rises only once the whole chain is full.
// o_valid_res and o_decision are low on each result until nine pixels have been taken.
// The configuration port (i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data)
// is always ready; indexes 0 to 2 load packed coefficients, index 3 the
// signed threshold, higher indexes are ignored. Write it only while idle.
// Reset clears the window, the fill count, the configuration and the chain's valid flags.
// ----------------------------------------------------------------------------
module fir_threshold_binarizer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // pixel input
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [fbt_pkg::PIXEL_BITS-1:0] i_pixel,
    // result output
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_decision,
    output logic                           o_valid_res,
    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [fbt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fbt_pkg::CFG_W-1:0]      i_cfg_data
);
    import fbt_pkg::*;

    logic [CFG_W-1:0] r_coeff [COEFF_REGS];
    t_level           r_level;
    t_coeff           w_coeff [TAPS];
    t_mac_word        w_word  [TAPS+1];
    logic             w_take  [TAPS+1];

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff[0] <= '0;
            r_coeff[1] <= '0;
            r_coeff[2] <= '0;
            r_level    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_COEFF_TAPS_0_2: r_coeff[0] <= i_cfg_data;
                REG_COEFF_TAPS_3_5: r_coeff[1] <= i_cfg_data;
                REG_COEFF_TAPS_6_8: r_coeff[2] <= i_cfg_data;
                REG_DECISION_LEVEL: r_level    <= i_cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // coefficient of each tap from its slot
    for (genvar k = 0; k < TAPS; k++) begin : g_coeff
        assign w_coeff[k] =
            r_coeff[k / PER_REG][(k % PER_REG) * SLOT_BITS +: COEFF_BITS];
    end

    // window and fill count
    fbt_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_pixel    (i_pixel),
        .i_take     (w_take[0]),
        .o_word     (w_word[0])
    );

    assign o_in_stall = !w_take[0];

    // multiply-accumulate chain, one cell per tap
    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        fbt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_coeff (w_coeff[k]),
            .i_word  (w_word[k]),
            .o_take  (w_take[k]),
            .o_word  (w_word[k+1]),
            .i_take  (w_take[k+1])
        );
    end

    // threshold and output register
    fbt_decide u_decide (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_level     (r_level),
        .i_word      (w_word[TAPS]),
        .o_take      (w_take[TAPS]),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_decision  (o_decision),
        .o_valid_res (o_valid_res)
    );

endmodule

[src/fbt_window.sv]
// ----------------------------------------------------------------------------
// fbt_window: pixel window and fill counter
// Shifts each accepted pixel into the window and starts a word for the cell
// chain carrying the updated window, a zero sum and the window-full flag.
// ----------------------------------------------------------------------------
module fbt_window (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  fbt_pkg::t_pix      i_pixel,
    input  logic               i_take,
    output fbt_pkg::t_mac_word o_word
);
    import fbt_pkg::*;

    t_win              r_win;
    t_win              n_win;
    logic [FILL_W-1:0] r_fill;
    logic              w_accept;

    assign w_accept = i_in_valid && i_take;

    // oldest pixel in entry 0, newest enters at the top
    assign n_win = {i_pixel, r_win[TAPS-1:1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= '0;
            r_fill <= '0;
        end else if (w_accept) begin
            r_win <= n_win;
            if (r_fill != FILL_W'(TAPS)) begin
                r_fill <= r_fill + FILL_W'(1);
            end
        end
    end

    // word offered to the first cell
    always_comb begin
        o_word      = '0;
        o_word.vld  = i_in_valid;
        o_word.full = (r_fill >= FILL_W'(TAPS - 1));
        o_word.pix  = n_win;
    end

endmodule

[src/fbt_cell.sv]
// ----------------------------------------------------------------------------
// fbt_cell: one multiply-accumulate cell of the chain
// Multiplies the lowest pixel of the incoming word by its coefficient, adds it
// to the running sum and hands the word on with the pixels shifted down.
// ----------------------------------------------------------------------------
module fbt_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fbt_pkg::t_coeff    i_coeff,
    input  fbt_pkg::t_mac_word i_word,
    output logic               o_take,
    output fbt_pkg::t_mac_word o_word,
    input  logic               i_take
);
    import fbt_pkg::*;

    logic                    r_vld;
    logic                    r_full;
    logic signed [ACC_W-1:0] r_psum;
    t_win                    r_pix;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [ACC_W-1:0] n_psum;
    t_win                    n_pix;

    // stage is free when empty or when its word moves on
    assign o_take = !r_vld || i_take;

    // unsigned pixel times signed coefficient
    assign w_prod = PROD_W'($signed({1'b0, i_word.pix[0]})) * PROD_W'(i_coeff);
    assign n_psum = i_word.psum + ACC_W'(w_prod);
    assign n_pix  = i_word.pix >> PIXEL_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_take) begin
            r_vld <= i_word.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_word.vld) begin
            r_full <= i_word.full;
            r_psum <= n_psum;
            r_pix  <= n_pix;
        end
    end

    always_comb begin
        o_word.vld  = r_vld;
        o_word.full = r_full;
        o_word.psum = r_psum;
        o_word.pix  = r_pix;
    end

endmodule

[src/fbt_decide.sv]
// ----------------------------------------------------------------------------
// fbt_decide: threshold compare and output register
// Compares the finished sum with the decision level and holds the result word
// until the receiver takes it.
// ----------------------------------------------------------------------------
module fbt_decide (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fbt_pkg::t_level    i_level,
    input  fbt_pkg::t_mac_word i_word,
    output logic               o_take,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_decision,
    output logic               o_valid_res
);
    import fbt_pkg::*;

    logic                    r_out_valid;
    logic                    r_decision;
    logic                    r_valid_res;
    logic signed [CMP_W-1:0] w_sum;
    logic signed [CMP_W-1:0] w_thr;
    logic                    n_decision;

    assign o_take = !r_out_valid || !i_out_stall;

    // sign-extended compare, forced low until the window is full
    assign w_sum      = CMP_W'(i_word.psum);
    assign w_thr      = CMP_W'(i_level);
    assign n_decision = i_word.full && (w_sum >= w_thr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= i_word.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_word.vld) begin
            r_decision  <= n_decision;
            r_valid_res <= i_word.full;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_decision  = r_decision;
    assign o_valid_res = r_valid_res;

endmodule
